// ----- hw/rtl/tkas_pkg.sv -----
// shared types, constants and codes for the running top-k sum tracker
package tkas_pkg;

    // default sizing, handed to the top level parameters
    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 20;

    // fixed field widths of the request and response
    localparam int ID_W      = 10;
    localparam int VALUE_W   = 20;
    localparam int K_W       = 11;
    localparam int RSP_SUM_W = 30;
    localparam int COUNT_W   = 11;

    localparam logic [K_W-1:0]       K_RESET   = K_W'(1);
    localparam logic [RSP_SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef enum logic [1:0]
    {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed
    {
        op_t                op;
        logic [ID_W-1:0]    item_id;
        logic [VALUE_W-1:0] item_value;
    } cmd_t;

    typedef struct packed
    {
        logic [RSP_SUM_W-1:0] current_sum;
        logic [RSP_SUM_W-1:0] best_sum;
        logic [COUNT_W-1:0]   active_count;
        logic                 status;
    } rsp_t;

    // broadcast command to every cell of the sorted chain
    typedef enum logic [1:0]
    {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_CLEAR  = 2'd3
    } cell_cmd_t;

    typedef struct packed
    {
        cell_cmd_t       cmd;
        logic [ID_W-1:0] item_id;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/tkas_cell.sv -----
// one cell of the sorted chain: holds one item and shifts with its neighbors
module tkas_cell
    import tkas_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic                  left_ge,
    input  logic                  left_valid,
    input  logic [ID_W-1:0]       left_id,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  right_valid,
    input  logic [ID_W-1:0]       right_id,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic                  at_or_after,
    output logic                  valid,
    output logic [ID_W-1:0]       id,
    output logic [VALUE_BITS-1:0] value,
    output logic                  ge,
    output logic                  hit
);

    logic                  valid_reg, valid_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    always_comb
    begin
        ge         = valid_reg && (value_reg >= new_value);
        hit        = valid_reg && (id_reg == ctrl.item_id);
        valid_next = valid_reg;
        id_next    = id_reg;
        value_next = value_reg;
        case (ctrl.cmd)
            CELL_INSERT:
            begin
                // equal values stay ahead of the new item
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        valid_next = 1'b1;
                        id_next    = ctrl.item_id;
                        value_next = new_value;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        value_next = left_value;
                    end
                end
            end
            CELL_REMOVE:
            begin
                if (at_or_after)
                begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    value_next = right_value;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign value = value_reg;

endmodule

// ----- hw/rtl/tkas_or_tree.sv -----
// registered binary or-reduction tree, one register level per tree level
module tkas_or_tree
    import tkas_pkg::*;
#(
    parameter int N = CAPACITY_DEF,
    parameter int W = ID_W + 1
)
(
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] root
);

    localparam int LV = $clog2(N);
    localparam int P  = 1 << LV;

    logic [W-1:0] leaf_pad [P];
    logic [W-1:0] node_reg [P-1];

    for (genvar k = 0; k < P; k++)
    begin : g_leaf
        if (k < N)
        begin : g_used
            assign leaf_pad[k] = leaf[k];
        end
        else
        begin : g_pad
            assign leaf_pad[k] = '0;
        end
    end

    for (genvar j = 0; j < P - 1; j++)
    begin : g_node
        localparam int L = 2 * j + 1;
        localparam int R = 2 * j + 2;
        logic [W-1:0] a;
        logic [W-1:0] b;
        if (L >= P - 1)
        begin : g_leaf_kids
            assign a = leaf_pad[L-(P-1)];
            assign b = leaf_pad[R-(P-1)];
        end
        else
        begin : g_node_kids
            assign a = node_reg[L];
            assign b = node_reg[R];
        end
        always_ff @(posedge clk)
        begin
            node_reg[j] <= a | b;
        end
    end

    assign root = node_reg[0];

endmodule

// ----- hw/rtl/tkas_add_tree.sv -----
// registered binary adder tree, one register level per tree level
module tkas_add_tree
    import tkas_pkg::*;
#(
    parameter int N = CAPACITY_DEF,
    parameter int W = VALUE_BITS_DEF + ID_W
)
(
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] root
);

    localparam int LV = $clog2(N);
    localparam int P  = 1 << LV;

    logic [W-1:0] leaf_pad [P];
    logic [W-1:0] node_reg [P-1];

    for (genvar k = 0; k < P; k++)
    begin : g_leaf
        if (k < N)
        begin : g_used
            assign leaf_pad[k] = leaf[k];
        end
        else
        begin : g_pad
            assign leaf_pad[k] = '0;
        end
    end

    // width covers the full sum, so no node can wrap
    for (genvar j = 0; j < P - 1; j++)
    begin : g_node
        localparam int L = 2 * j + 1;
        localparam int R = 2 * j + 2;
        logic [W-1:0] a;
        logic [W-1:0] b;
        if (L >= P - 1)
        begin : g_leaf_kids
            assign a = leaf_pad[L-(P-1)];
            assign b = leaf_pad[R-(P-1)];
        end
        else
        begin : g_node_kids
            assign a = node_reg[L];
            assign b = node_reg[R];
        end
        always_ff @(posedge clk)
        begin
            node_reg[j] <= a + b;
        end
    end

    assign root = node_reg[0];

endmodule

// ----- hw/rtl/top_k_active_sum_tracker.sv -----
// top level of the running top-k sum tracker: sorted cell chain, trees and sequencer
//
// usage
// - request channel (cmd_valid / cmd_stall / cmd): one op per request, insert,
//   remove by id, close tick or clear all. cmd_stall is high while a request
//   is in progress; the next request is taken once the sequencer is idle again
// - response channel (rsp_valid / rsp_stall / rsp): exactly one response per
//   request, in order. the response sits in an output register, so a new
//   request is taken while an earlier response still waits on a stalled
//   receiver; a finished op holds in its last state until that register frees
// - cfg_wen / cfg_wdata write k_chosen; write only while no request is open
// - op steps: insert and remove search the id through the or-tree, shift the
//   chain once, then sum through the adder tree; close only sums through the
//   adder tree, and clear empties the chain and the state directly. the two
//   pipelined reduction trees set how long insert, remove and close take
// - reset empties the chain, zeroes the sums and the count, and sets
//   k_chosen to 1; a clear request does the same except for k_chosen
module top_k_active_sum_tracker
    import tkas_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  cmd_t           cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rsp_t           rsp,
    input  logic           cfg_wen,
    input  logic [K_W-1:0] cfg_wdata
);

    // chain index, count and tree sizing
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LV         = $clog2(CAPACITY);
    localparam int LAT_W      = $clog2(LV + 1);
    localparam int OR_W       = IDX_W + 1;
    localparam int TREE_SUM_W = VALUE_BITS + IDX_W;
    localparam int SAT_W      = (TREE_SUM_W > RSP_SUM_W) ? TREE_SUM_W : RSP_SUM_W;
    localparam int CSAT_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int KC_W       = (IDX_W > K_W) ? IDX_W : K_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FIND,
        ST_SUM,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [LAT_W-1:0]      cnt_reg, cnt_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [RSP_SUM_W-1:0]  sum_now_reg, sum_now_next;
    logic [RSP_SUM_W-1:0]  best_reg, best_next;
    logic                  status_reg, status_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // latched request payload
    op_t                   op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [VALUE_BITS-1:0] val_reg;
    rsp_t                  rsp_reg;

    logic                  cmd_take;
    logic                  rsp_load;

    // chain wiring
    cell_ctrl_t            cell_ctrl;
    logic                  cell_valid [CAPACITY];
    logic [ID_W-1:0]       cell_id    [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic                  cell_ge    [CAPACITY];
    logic                  cell_hit   [CAPACITY];
    logic                  left_ge    [CAPACITY];
    logic                  left_valid [CAPACITY];
    logic [ID_W-1:0]       left_id    [CAPACITY];
    logic [VALUE_BITS-1:0] left_value [CAPACITY];
    logic                  right_valid [CAPACITY];
    logic [ID_W-1:0]       right_id    [CAPACITY];
    logic [VALUE_BITS-1:0] right_value [CAPACITY];
    logic                  at_or_after [CAPACITY];

    // reduction trees
    logic [OR_W-1:0]       or_leaf  [CAPACITY];
    logic [OR_W-1:0]       or_root;
    logic [TREE_SUM_W-1:0] sum_leaf [CAPACITY];
    logic [TREE_SUM_W-1:0] sum_root;

    logic                  found;
    logic [IDX_W-1:0]      at_idx;
    logic                  lat_done;
    logic                  chain_full;
    logic [SAT_W-1:0]      sum_ext;
    logic [RSP_SUM_W-1:0]  sum_sat;
    logic [CSAT_W-1:0]     count_ext;
    logic [COUNT_W-1:0]    count_sat;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;

    // or-tree root carries the hit flag and the index of the matching cell
    assign found      = or_root[IDX_W];
    assign at_idx     = or_root[IDX_W-1:0];
    assign lat_done   = (cnt_reg == LAT_W'(LV));
    assign chain_full = (count_reg == CNT_W'(CAPACITY));

    // saturate the sum and the reported count to their field widths
    assign sum_ext   = SAT_W'(sum_root);
    assign sum_sat   = (sum_ext > SAT_W'(SUM_MAX)) ? SUM_MAX : RSP_SUM_W'(sum_ext);
    assign count_ext = CSAT_W'(count_reg);
    assign count_sat = (count_ext > CSAT_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_ext);

    // broadcast to the chain: shift on the cycle the search result is in, clear in ST_CLEAR
    always_comb
    begin
        cell_ctrl.item_id = id_reg;
        cell_ctrl.cmd     = CELL_HOLD;
        case (state_reg)
            ST_FIND:
            begin
                if (lat_done)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (!found && !chain_full)
                        begin
                            cell_ctrl.cmd = CELL_INSERT;
                        end
                    end
                    else if (found)
                    begin
                        cell_ctrl.cmd = CELL_REMOVE;
                    end
                end
            end
            ST_CLEAR:
            begin
                cell_ctrl.cmd = CELL_CLEAR;
            end
            default:
            begin
                cell_ctrl.cmd = CELL_HOLD;
            end
        endcase
    end

    // the chain itself, with its end cells tied off
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            assign left_ge[i]    = 1'b1;
            assign left_valid[i] = 1'b0;
            assign left_id[i]    = '0;
            assign left_value[i] = '0;
        end
        else
        begin : g_mid_left
            assign left_ge[i]    = cell_ge[i-1];
            assign left_valid[i] = cell_valid[i-1];
            assign left_id[i]    = cell_id[i-1];
            assign left_value[i] = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_valid[i] = 1'b0;
            assign right_id[i]    = '0;
            assign right_value[i] = '0;
        end
        else
        begin : g_mid_right
            assign right_valid[i] = cell_valid[i+1];
            assign right_id[i]    = cell_id[i+1];
            assign right_value[i] = cell_value[i+1];
        end

        assign at_or_after[i] = (IDX_W'(i) >= at_idx);

        // id search leaf and top-k sum leaf of this cell
        assign or_leaf[i]  = cell_hit[i] ? {1'b1, IDX_W'(i)} : '0;
        assign sum_leaf[i] = (cell_valid[i] && (KC_W'(i) < KC_W'(k_reg)))
                           ? TREE_SUM_W'(cell_value[i]) : '0;

        tkas_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .new_value   (val_reg),
            .left_ge     (left_ge[i]),
            .left_valid  (left_valid[i]),
            .left_id     (left_id[i]),
            .left_value  (left_value[i]),
            .right_valid (right_valid[i]),
            .right_id    (right_id[i]),
            .right_value (right_value[i]),
            .at_or_after (at_or_after[i]),
            .valid       (cell_valid[i]),
            .id          (cell_id[i]),
            .value       (cell_value[i]),
            .ge          (cell_ge[i]),
            .hit         (cell_hit[i])
        );
    end

    tkas_or_tree #(
        .N (CAPACITY),
        .W (OR_W)
    ) u_or_tree (
        .clk  (clk),
        .leaf (or_leaf),
        .root (or_root)
    );

    tkas_add_tree #(
        .N (CAPACITY),
        .W (TREE_SUM_W)
    ) u_add_tree (
        .clk  (clk),
        .leaf (sum_leaf),
        .root (sum_root)
    );

    // sequencer: search, shift, sum (close only sums, clear only empties), then load the output register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = cfg_wen ? cfg_wdata : k_reg;
        count_next     = count_reg;
        sum_now_next   = sum_now_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    cnt_next    = '0;
                    status_next = STATUS_DONE;
                    case (cmd.op)
                        OP_INSERT, OP_REMOVE: state_next = ST_FIND;
                        OP_CLOSE:             state_next = ST_SUM;
                        default:              state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_FIND:
            begin
                // wait for the or-tree result to come through its register levels
                if (lat_done)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (found || chain_full)
                        begin
                            status_next = STATUS_IGNORED;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (!found)
                    begin
                        status_next = STATUS_IGNORED;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + LAT_W'(1);
                end
            end
            ST_SUM:
            begin
                // sum always follows the present k_chosen
                if (lat_done)
                begin
                    sum_now_next = sum_sat;
                    if ((op_reg == OP_CLOSE) && (sum_sat > best_reg))
                    begin
                        best_next = sum_sat;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + LAT_W'(1);
                end
            end
            ST_CLEAR:
            begin
                count_next   = '0;
                sum_now_next = '0;
                best_next    = '0;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // wait here while the previous response is still stalled
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_load       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= K_RESET;
            count_reg     <= '0;
            sum_now_reg   <= '0;
            best_reg      <= '0;
            status_reg    <= STATUS_DONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            sum_now_reg   <= sum_now_next;
            best_reg      <= best_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // request payload and response payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg  <= cmd.op;
            id_reg  <= cmd.item_id;
            val_reg <= VALUE_BITS'(cmd.item_value);
        end
        if (rsp_load)
        begin
            rsp_reg.current_sum  <= sum_now_reg;
            rsp_reg.best_sum     <= best_reg;
            rsp_reg.active_count <= count_sat;
            rsp_reg.status       <= status_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // a response only appears out of the hand-off state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the hand-off state");

    // the chain never gets an insert when it is full
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.cmd == CELL_INSERT) |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("insert shifted into a full chain");

    // a clear empties both the count and the chain head
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.cmd == CELL_CLEAR) |=> ((count_reg == '0) && !cell_valid[0]))
        else $error("clear left items behind");

    // the head cell is occupied exactly when the count is nonzero
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0] == (count_reg != '0))
        else $error("chain head and active count disagree");
`endif

endmodule

// ----- bench/tb_top_k_active_sum_tracker.sv -----
// self-checking testbench for the running top-k sum tracker
`timescale 1ns / 1ps

module tb_top_k_active_sum_tracker;
    import tkas_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 8;
    localparam int DIRECTED_N   = 23;

    // one row of the directed table: optional k write ahead of the request,
    // the request itself, and a hand-typed response where it is obvious
    typedef struct
    {
        bit                   set_k;
        logic [K_W-1:0]       k_val;
        op_t                  op;
        logic [ID_W-1:0]      id;
        logic [VALUE_W-1:0]   val;
        bit                   typed;
        logic [RSP_SUM_W-1:0] e_sum;
        logic [RSP_SUM_W-1:0] e_best;
        logic [COUNT_W-1:0]   e_count;
        logic                 e_status;
    } req_row_t;

    logic           clk;
    logic           rst_n = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    cmd_t           cmd = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    rsp_t           rsp;
    logic           cfg_wen = 1'b0;
    logic [K_W-1:0] cfg_wdata = '0;

    // checking state
    rsp_t pending_rsp [$];
    rsp_t oldest_rsp;
    int   mismatch_count = 0;
    int   rsp_seen = 0;
    int   cycle_count = 0;

    // shadow of the tracker: values sorted largest first, plus per-id records
    logic [VALUE_W-1:0]   value_of_id [CAPACITY_DEF];
    bit                   id_active [CAPACITY_DEF];
    int unsigned          sorted_vals [$];
    int unsigned          live_ids [$];
    logic [K_W-1:0]       k_now = K_RESET;
    logic [RSP_SUM_W-1:0] best_now = '0;

    // sender burst bookkeeping
    int burst_left = 0;

    // directed requests, all at reset k = 1 until the first k write
    req_row_t directed_rows [DIRECTED_N] = '{
        // empty tracker: close and a remove of an absent id
        '{1'b0, 11'd0, OP_CLOSE,  10'd0,    20'd0,       1'b1,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_REMOVE, 10'd5,    20'd0,       1'b1,
          30'd0, 30'd0, 11'd0, STATUS_IGNORED},
        // lowest id with zero value, then highest id with full-scale value
        '{1'b0, 11'd0, OP_INSERT, 10'd0,    20'd0,       1'b1,
          30'd0, 30'd0, 11'd1, STATUS_DONE},
        '{1'b0, 11'd0, OP_INSERT, 10'd1023, 20'hFFFFF,   1'b1,
          30'hFFFFF, 30'd0, 11'd2, STATUS_DONE},
        // duplicate insert is dropped
        '{1'b0, 11'd0, OP_INSERT, 10'd1023, 20'd7,       1'b1,
          30'hFFFFF, 30'd0, 11'd2, STATUS_IGNORED},
        '{1'b0, 11'd0, OP_CLOSE,  10'd0,    20'd0,       1'b1,
          30'hFFFFF, 30'hFFFFF, 11'd2, STATUS_DONE},
        // equal value goes behind the existing one, sum unchanged
        '{1'b0, 11'd0, OP_INSERT, 10'd512,  20'hFFFFF,   1'b1,
          30'hFFFFF, 30'hFFFFF, 11'd3, STATUS_DONE},
        // alternating bit patterns on id and value
        '{1'b0, 11'd0, OP_INSERT, 10'h2AA,  20'h55555,   1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_INSERT, 10'h155,  20'hAAAAA,   1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_REMOVE, 10'd1023, 20'd0,       1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        // second remove of the same id is absent
        '{1'b0, 11'd0, OP_REMOVE, 10'd1023, 20'hFFFFF,   1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_CLOSE,  10'd0,    20'd0,       1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        // clear wipes sums and count, k stays
        '{1'b0, 11'd0, OP_CLEAR,  10'h3FF,  20'hFFFFF,   1'b1,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_REMOVE, 10'd0,    20'd0,       1'b1,
          30'd0, 30'd0, 11'd0, STATUS_IGNORED},
        // k = 3 with more items than k
        '{1'b1, 11'd3, OP_INSERT, 10'd10,   20'd100,     1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_INSERT, 10'd11,   20'd200,     1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_INSERT, 10'd12,   20'd300,     1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_INSERT, 10'd13,   20'd50,      1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_CLOSE,  10'd0,    20'd0,       1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        // k of zero sums nothing, best stays from the last close
        '{1'b1, 11'd0, OP_CLOSE,  10'd0,    20'd0,       1'b1,
          30'd0, 30'd600, 11'd4, STATUS_DONE},
        // k far above the active count sums everything
        '{1'b1, 11'd2047, OP_INSERT, 10'd14, 20'd1,      1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_REMOVE, 10'd12,   20'd0,       1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE},
        '{1'b0, 11'd0, OP_CLOSE,  10'd0,    20'd0,       1'b0,
          30'd0, 30'd0, 11'd0, STATUS_DONE}
    };

    top_k_active_sum_tracker u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // empty the shadow chain; the running best goes with it
    function automatic void forget_all();
        sorted_vals.delete();
        live_ids.delete();
        foreach (id_active[i])
            id_active[i] = 1'b0;
        best_now = '0;
    endfunction

    // apply one request to the shadow tracker and return its response
    function automatic rsp_t track_top_k(cmd_t c);
        rsp_t            r;
        int              pos;
        int unsigned     n;
        longint unsigned acc;
        int              idx [$];
        r = '0;
        r.status = STATUS_DONE;
        case (c.op)
            OP_INSERT:
            begin
                if (sorted_vals.size() >= CAPACITY_DEF || id_active[c.item_id])
                    r.status = STATUS_IGNORED;
                else
                begin
                    // ties land behind existing equal values
                    pos = 0;
                    while (pos < sorted_vals.size() && sorted_vals[pos] >= c.item_value)
                        pos++;
                    sorted_vals.insert(pos, 32'(c.item_value));
                    id_active[c.item_id] = 1'b1;
                    value_of_id[c.item_id] = c.item_value;
                    live_ids.insert(live_ids.size(), 32'(c.item_id));
                end
            end
            OP_REMOVE:
            begin
                if (!id_active[c.item_id])
                    r.status = STATUS_IGNORED;
                else
                begin
                    // any copy of an equal value gives the same sums
                    idx = sorted_vals.find_first_index(x) with (x == value_of_id[c.item_id]);
                    sorted_vals.delete(idx[0]);
                    idx = live_ids.find_first_index(x) with (x == c.item_id);
                    live_ids.delete(idx[0]);
                    id_active[c.item_id] = 1'b0;
                end
            end
            OP_CLEAR:
                forget_all();
            default:
                ;
        endcase
        acc = 0;
        if (c.op != OP_CLEAR)
        begin
            n = (k_now < sorted_vals.size()) ? k_now : sorted_vals.size();
            for (int i = 0; i < n; i++)
                acc += sorted_vals[i];
        end
        r.current_sum = (acc > SUM_MAX) ? SUM_MAX : acc[RSP_SUM_W-1:0];
        if (c.op == OP_CLOSE && r.current_sum > best_now)
            best_now = r.current_sum;
        r.best_sum = best_now;
        r.active_count = (sorted_vals.size() > COUNT_MAX) ? COUNT_MAX
                                                          : COUNT_W'(sorted_vals.size());
        return r;
    endfunction

    // random request, mostly well-formed against the shadow state
    function automatic cmd_t pick_request(int insert_weight);
        cmd_t c;
        int   r;
        int   tries;
        r = $urandom_range(0, insert_weight + 49);
        c.item_id = ID_W'($urandom_range(0, CAPACITY_DEF - 1));
        case ($urandom_range(0, 9))
            6, 7:    c.item_value = VALUE_W'($urandom_range(0, 15));   // lots of equal values
            8:       c.item_value = '0;
            9:       c.item_value = '1;
            default: c.item_value = VALUE_W'($urandom);
        endcase
        tries = 0;
        if (r < insert_weight)
        begin
            // fresh id
            c.op = OP_INSERT;
            while (id_active[c.item_id] && tries < 16)
            begin
                c.item_id = ID_W'($urandom_range(0, CAPACITY_DEF - 1));
                tries++;
            end
        end
        else if (r < insert_weight + 25)
        begin
            c.op = OP_REMOVE;
            if (live_ids.size() != 0)
                c.item_id = ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        end
        else if (r < insert_weight + 37)
            c.op = OP_CLOSE;
        else if (r < insert_weight + 41)
        begin
            // duplicate insert
            c.op = OP_INSERT;
            if (live_ids.size() != 0)
                c.item_id = ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        end
        else if (r < insert_weight + 45)
        begin
            // remove of an id that is not active
            c.op = OP_REMOVE;
            while (id_active[c.item_id] && tries < 16)
            begin
                c.item_id = ID_W'($urandom_range(0, CAPACITY_DEF - 1));
                tries++;
            end
        end
        else if (r < insert_weight + 47)
            c.op = OP_CLEAR;
        else
            c = cmd_t'($urandom);   // noise on every bit
        return c;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch %s at cycle %0d: got %0d expected %0d",
                     what, cycle_count, got, want);
    endtask

    // present one request, hold it until taken, then log its expected response;
    // a typed row overrides the shadow's answer but the shadow still steps
    task automatic offer_request(cmd_t c, bit typed, rsp_t typed_rsp);
        rsp_t predicted;
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = track_top_k(c);
        pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : predicted);
        // bursts of back-to-back requests, then an idle gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    // k changes only with nothing in flight and the sequencer settled
    task automatic write_k(logic [K_W-1:0] k);
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_wen <= 1'b0;
        k_now = k;
    endtask

    // response side: check every taken response against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response", 64'(rsp.current_sum), 64'd0);
            else
            begin
                oldest_rsp = pending_rsp.pop_front();
                if (rsp.current_sum !== oldest_rsp.current_sum)
                    report_mismatch("current_sum", 64'(rsp.current_sum),
                                    64'(oldest_rsp.current_sum));
                if (rsp.best_sum !== oldest_rsp.best_sum)
                    report_mismatch("best_sum", 64'(rsp.best_sum), 64'(oldest_rsp.best_sum));
                if (rsp.active_count !== oldest_rsp.active_count)
                    report_mismatch("active_count", 64'(rsp.active_count),
                                    64'(oldest_rsp.active_count));
                if (rsp.status !== oldest_rsp.status)
                    report_mismatch("status", 64'(rsp.status), 64'(oldest_rsp.status));
            end
            rsp_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern: segments of no stall, light and heavy stalling,
    // plus one long hold-off so the output register fills and the input stalls
    initial
    begin
        bit hold_done;
        int mode;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && rsp_seen >= 60)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(10, 80))
                begin
                    case (mode)
                        0:       rsp_stall <= 1'b0;
                        1:       rsp_stall <= ($urandom_range(0, 99) < 30);
                        default: rsp_stall <= ($urandom_range(0, 99) < 70);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // request side: reset, directed table, then random phases at several k
    initial
    begin
        logic [K_W-1:0] phase_k [PHASES];
        rsp_t           typed_rsp;
        cmd_t           c;
        forget_all();
        phase_k = '{11'd1024, 11'd1, 11'd2, 11'd2047, 11'd0, 11'd5, 11'd0, 11'd0};
        phase_k[6] = K_W'($urandom_range(1, 64));
        phase_k[7] = K_W'($urandom_range(65, 2047));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_k)
                write_k(directed_rows[i].k_val);
            c.op = directed_rows[i].op;
            c.item_id = directed_rows[i].id;
            c.item_value = directed_rows[i].val;
            typed_rsp.current_sum = directed_rows[i].e_sum;
            typed_rsp.best_sum = directed_rows[i].e_best;
            typed_rsp.active_count = directed_rows[i].e_count;
            typed_rsp.status = directed_rows[i].e_status;
            offer_request(c, directed_rows[i].typed, typed_rsp);
        end

        // first phase leans on inserts so the chain grows under a large k
        for (int p = 0; p < PHASES; p++)
        begin
            write_k(phase_k[p]);
            repeat (PHASE_ITEMS)
                offer_request(pick_request((p == 0) ? 150 : 50), 1'b0, typed_rsp);
        end

        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
